// ===== hw/rtl/mna_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mna_pkg: shared types and constants of the note arpeggiator
// Widths of the held-note list, request codes, state encoding and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mna_pkg;

   localparam int MAX_HELD = 16;
   localparam int IDX_W    = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
   localparam int CNT_W    = $clog2(MAX_HELD + 1);
   localparam int NOTE_W   = 7;
   localparam int STEP_W   = 24;
   localparam int CMD_W    = 2;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(6000);
   localparam logic [STEP_W-1:0] TICK_MAX   = {STEP_W{1'b1}};
   localparam logic [CNT_W-1:0]  HELD_FULL  = CNT_W'(MAX_HELD);

   // request codes; the fourth code is ignored
   localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_REMOVE,
      ST_MOD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic latch;
      logic add;
      logic rem_init;
      logic rem_step;
      logic tick;
      logic mod_step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             list_empty;
      logic             rem_done;
      logic             mod_done;
      logic             tick_hit;
      logic             out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mna_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mna_ctrl: arpeggiator controller
// Sequences one request at a time through decode, list compaction,
// play position wrap and result hand-off.
// ----------------------------------------------------------------------------
module mna_ctrl import mna_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire dp_status_type status,
   output      ctrl_cmd_type  cmd,
   output      state_type     state
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.cmd)
               CMD_NOTE_ON:  state_in = ST_IDLE;
               CMD_NOTE_OFF: state_in = ST_REMOVE;
               CMD_TICK: begin
                  if (!status.list_empty && status.tick_hit) state_in = ST_MOD;
                  else state_in = ST_IDLE;
               end
               default:      state_in = ST_IDLE;
            endcase
         end
         ST_REMOVE: begin
            if (status.rem_done) state_in = ST_IDLE;
         end
         ST_MOD: begin
            if (status.mod_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.latch    = req_valid;
         ST_DECODE: begin
            cmd.add      = (status.cmd == CMD_NOTE_ON);
            cmd.rem_init = (status.cmd == CMD_NOTE_OFF);
            cmd.tick     = (status.cmd == CMD_TICK);
         end
         ST_REMOVE: cmd.rem_step = 1'b1;
         ST_MOD:    cmd.mod_step = 1'b1;
         ST_EMIT:   cmd.load_out = status.out_free;
         default:   cmd = '0;
      endcase
   end

   assign state = state_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/mna_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mna_dpath: arpeggiator datapath
// Held-note memory, count, tick counter, play position, step length
// register and the result register.
// ----------------------------------------------------------------------------
module mna_dpath import mna_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctrl_cmd_type      cmd,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [NOTE_W-1:0] req_note,
   input  wire logic              csr_wr_en,
   input  wire logic [STEP_W-1:0] csr_wr_data,
   input  wire logic              rsp_stall,
   output      logic              rsp_valid,
   output      logic [NOTE_W-1:0] rsp_play_note,
   output      dp_status_type     status
);

   logic [NOTE_W-1:0] mem [MAX_HELD];
   logic [NOTE_W-1:0] mem_q;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   logic [NOTE_W-1:0] mem_wd;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_ra;

   logic [CMD_W-1:0]  cmd_ff;
   logic [NOTE_W-1:0] note_ff;
   logic [CNT_W-1:0]  pos_tmp_ff, pos_tmp_in;

   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [STEP_W-1:0] tick_ff, tick_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NOTE_W-1:0] rsp_note_ff, rsp_note_in;

   logic [STEP_W-1:0] tick_next;
   logic              tick_hit;
   logic              out_free;
   logic              rem_done;
   logic              mod_done;

   assign tick_next = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + STEP_W'(1);
   assign tick_hit  = (tick_next >= step_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rem_done  = (rd_ff == count_ff) && !pend_ff;
   assign mod_done  = (pos_tmp_ff < count_ff);

   always_comb begin
      step_in      = csr_wr_en ? csr_wr_data : step_ff;
      count_in     = count_ff;
      tick_in      = tick_ff;
      pos_in       = pos_ff;
      pos_tmp_in   = pos_tmp_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_note_in  = rsp_note_ff;
      mem_we       = 1'b0;
      mem_wa       = count_ff[IDX_W-1:0];
      mem_wd       = note_ff;
      mem_re       = 1'b0;
      mem_ra       = rd_ff[IDX_W-1:0];

      // append
      if (cmd.add && (count_ff != HELD_FULL)) begin
         mem_we   = 1'b1;
         count_in = count_ff + CNT_W'(1);
      end

      if (cmd.rem_init) begin
         rd_in   = '0;
         wr_in   = '0;
         pend_in = 1'b0;
      end

      // compaction: read ahead one entry, keep the previous one if it differs from the removed note
      if (cmd.rem_step) begin
         if (rd_ff != count_ff) begin
            mem_re  = 1'b1;
            rd_in   = rd_ff + CNT_W'(1);
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff && (mem_q != note_ff)) begin
            mem_we = 1'b1;
            mem_wa = wr_ff[IDX_W-1:0];
            mem_wd = mem_q;
            wr_in  = wr_ff + CNT_W'(1);
         end
         if (rem_done) count_in = wr_ff;
      end

      if (cmd.tick && (count_ff != '0)) begin
         if (tick_hit) begin
            tick_in    = '0;
            pos_tmp_in = CNT_W'(pos_ff) + CNT_W'(1);
         end else begin
            tick_in = tick_next;
         end
      end

      // wrap the advanced position, then fetch its note
      if (cmd.mod_step) begin
         if (!mod_done) begin
            pos_tmp_in = pos_tmp_ff - count_ff;
         end else begin
            pos_in = pos_tmp_ff[IDX_W-1:0];
            mem_re = 1'b1;
            mem_ra = pos_tmp_ff[IDX_W-1:0];
         end
      end

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_note_in  = mem_q;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) mem_q <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff  <= req_cmd;
         note_ff <= req_note;
      end
      pos_tmp_ff  <= pos_tmp_in;
      rsp_note_ff <= rsp_note_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         count_ff     <= '0;
         tick_ff      <= '0;
         pos_ff       <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         tick_ff      <= tick_in;
         pos_ff       <= pos_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.cmd        = cmd_ff;
   assign status.list_empty = (count_ff == '0);
   assign status.rem_done   = rem_done;
   assign status.mod_done   = mod_done;
   assign status.tick_hit   = tick_hit;
   assign status.out_free   = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_play_note = rsp_note_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/midi_note_arpeggiator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_note_arpeggiator: as-played-order MIDI arpeggiator
// Keeps the held notes in press order and steps through them on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): cmd 0 note-on (append note, dropped when the
//   list holds 16 notes), cmd 1 note-off (remove every copy of the note),
//   cmd 2 tick (one processing block), cmd 3 ignored.
//   Response channel (rsp_*): rsp_play_note is the note to sound, meant as
//   note-on velocity 100 on channel 1. Only stepping ticks give a response.
//   csr_wr_en/csr_wr_data write step_length (ticks per step, reset 6000).
// Timing (one request at a time, req_stall high while busy):
//   note-on passes idle and decode; note-off adds the compaction walk over
//   the held list through the list memory's single read port; a tick that
//   does not step ends in decode; a stepping tick wraps the play position,
//   subtracting the held count while it lies at or beyond the list end.
//   The response sits in an output register; a new request is taken while
//   it waits, and only a further step result waits for the receiver.
// Reset: synchronous, clears the list, counters and play position and
//   restores step_length to 6000. A pending response is dropped.
// ----------------------------------------------------------------------------
module midi_note_arpeggiator import mna_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [NOTE_W-1:0] req_note,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [NOTE_W-1:0] rsp_play_note,
   input  wire logic              csr_wr_en,
   input  wire logic [STEP_W-1:0] csr_wr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   state_type     state;

   // controller: one request in flight, stall everything outside idle
   mna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   // datapath: list memory, counters and the response register
   mna_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_cmd       (req_cmd),
      .req_note      (req_note),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_play_note (rsp_play_note),
      .status        (status)
   );

   assign req_stall = (state != ST_IDLE);

   // an accepted request keeps the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but block not busy");

   // a response appears only out of the emit state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state == ST_EMIT))
      else $error("response raised outside emit");

   // a step is never emitted from an empty list
   assert property (@(posedge clock) disable iff (reset)
      (state == ST_EMIT) |-> !status.list_empty)
      else $error("emit with empty list");

endmodule
`default_nettype wire
